/* design/assert_macros.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/avsfs_pkg.sv */
// Shared types, field layout and constants of the frame scheduler.
package avsfs_pkg;

    // Picture queue and slot width.
    localparam int QUEUE_DEPTH = 4;
    localparam int SLOT_W      = 4;

    // Field widths.
    localparam int NOW_W    = 47;
    localparam int TIME_W   = 48;
    localparam int BUF_W    = 20;
    localparam int DELAY_W  = 21;
    localparam int ADJ_W    = DELAY_W + 1;
    localparam int SR_W     = 18;
    localparam int CH_W     = 4;
    localparam int SYNC_W   = 20;
    localparam int NOSYNC_W = 27;
    localparam int MS_W     = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    // Stream widths and field positions.
    localparam int IN_DATA_W     = 192;
    localparam int IN_USER_W     = 1;
    localparam int OUT_DATA_W    = 24;
    localparam int NOW_LSB       = 0;
    localparam int VIDEO_BIT     = 47;
    localparam int PICTURE_BIT   = 48;
    localparam int PTS_LSB       = 49;
    localparam int AUDIO_BIT     = 97;
    localparam int ACLK_LSB      = 98;
    localparam int BUF_SIZE_LSB  = 146;
    localparam int BUF_INDEX_LSB = 166;
    localparam int OUT_PAD_W     = OUT_DATA_W - MS_W - 1 - SLOT_W;

    // Datapath widths.
    localparam int NUM_W       = 40;
    localparam int BPS_W       = 23;
    localparam int STEP_W      = TIME_W + 1;
    localparam int DIFF_W      = 52;
    localparam int WAIT_W      = TIME_W + 1;
    localparam int ROUND_W     = 26;
    localparam int RECIP_W     = 27;
    localparam int PROD_W      = ROUND_W + RECIP_W;
    localparam int RECIP_SHIFT = 36;
    localparam int DIV_CNT_W   = 6;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(NUM_W);

    // Timing constants.
    localparam logic [BUF_W-1:0]         ONE_SECOND_US   = 20'd1000000;
    localparam logic signed [STEP_W-1:0] MAX_STEP_US     = 49'sd1000000;
    localparam logic signed [WAIT_W-1:0] MIN_WAIT_US     = 49'sd10000;
    localparam logic signed [WAIT_W-1:0] SAT_WAIT_US     = 49'sd65535500;
    localparam logic [ROUND_W-1:0]       HALF_MS_US      = 26'd500;
    localparam logic [RECIP_W-1:0]       RECIP_MS        = 27'd68719477;
    localparam logic [MS_W-1:0]          MAX_INTERVAL_MS = 16'd65535;
    localparam logic [MS_W-1:0]          NO_VIDEO_MS     = 16'd10;
    localparam logic [MS_W-1:0]          EMPTY_QUEUE_MS  = 16'd1;

    // Reset values of state and registers.
    localparam logic [DELAY_W-1:0]  DELAY_RESET  = 21'd40000;
    localparam logic [SR_W-1:0]     SR_RESET     = 18'd48000;
    localparam logic [CH_W-1:0]     CH_RESET     = 4'd2;
    localparam logic [SYNC_W-1:0]   SYNC_RESET   = 20'd10000;
    localparam logic [NOSYNC_W-1:0] NOSYNC_RESET = 27'd10000000;

    // Action codes carried in tuser.
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_RATE,
        REG_CHANNEL_COUNT,
        REG_SYNC_THRESHOLD,
        REG_NOSYNC_THRESHOLD
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_NO_VIDEO,
        KIND_EMPTY,
        KIND_FRAME
    } out_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      restart;
        logic      capture;
        logic      prep;
        logic      div_start;
        logic      ref_calc;
        logic      decide;
        logic      timer_adv;
        logic      wait_calc;
        logic      mul;
        logic      load_out;
        out_kind_t kind;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

/* design/avsfs_div.sv */
// Restoring divider, one quotient bit per cycle, for the audio correction.
`include "assert_macros.svh"

module avsfs_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [avsfs_pkg::NUM_W-1:0]  dividend,
    input  logic [avsfs_pkg::BPS_W-1:0]  divisor,
    output logic                         done,
    output logic [avsfs_pkg::NUM_W-1:0]  quotient
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [avsfs_pkg::DIV_CNT_W-1:0]  count_reg;
    logic [avsfs_pkg::BPS_W-1:0]      rem_reg;
    logic [avsfs_pkg::BPS_W-1:0]      divisor_reg;
    logic [avsfs_pkg::NUM_W-1:0]      quo_reg;
    logic [avsfs_pkg::BPS_W:0]        trial;
    logic [avsfs_pkg::BPS_W:0]        trial_sub;
    logic                             fits;

    // Shift in the next dividend bit and try a subtraction.
    assign trial     = {rem_reg, quo_reg[avsfs_pkg::NUM_W-1]};
    assign trial_sub = trial - {1'b0, divisor_reg};
    assign fits      = (trial >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (count_reg == avsfs_pkg::DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= avsfs_pkg::DIV_STEPS;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - avsfs_pkg::DIV_CNT_W'(1);
                if (count_reg == avsfs_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[avsfs_pkg::BPS_W-1:0] : trial[avsfs_pkg::BPS_W-1:0];
            quo_reg <= {quo_reg[avsfs_pkg::NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `ASSERT_IMP(a_start_when_idle, start, !busy_reg)
    `ASSERT_NXT(a_done_after_last_step, busy_reg && (count_reg == 6'd1), done_reg && !busy_reg)
    `ASSERT_NXT(a_done_is_pulse, done_reg, !done_reg)

endmodule

/* design/avsfs_datapath.sv */
// Datapath: registers, pts step, audio correction, sync decision and interval.
module avsfs_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  avsfs_pkg::cmd_t                    cmd,
    output avsfs_pkg::status_t                 status,
    input  logic [avsfs_pkg::IN_DATA_W-1:0]    in_data,
    input  logic                               cfg_we,
    input  logic [avsfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [avsfs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [avsfs_pkg::OUT_DATA_W-1:0]   out_data
);

    // Configuration registers.
    logic [avsfs_pkg::SR_W-1:0]      sample_rate_reg;
    logic [avsfs_pkg::CH_W-1:0]      channel_count_reg;
    logic [avsfs_pkg::SYNC_W-1:0]    sync_thr_reg;
    logic [avsfs_pkg::NOSYNC_W-1:0]  nosync_thr_reg;

    // Scheduler state.
    logic signed [avsfs_pkg::TIME_W-1:0] last_pts_reg;
    logic [avsfs_pkg::DELAY_W-1:0]       last_delay_reg;
    logic signed [avsfs_pkg::TIME_W-1:0] frame_timer_reg;
    logic [avsfs_pkg::SLOT_W-1:0]        read_slot_reg;

    // Captured item.
    logic [avsfs_pkg::NOW_W-1:0]         now_reg;
    logic signed [avsfs_pkg::TIME_W-1:0] pts_reg;
    logic signed [avsfs_pkg::TIME_W-1:0] aclk_reg;
    logic                                audio_reg;
    logic [avsfs_pkg::BUF_W-1:0]         buf_size_reg;
    logic [avsfs_pkg::BUF_W-1:0]         buf_index_reg;

    // Working registers.
    logic [avsfs_pkg::DELAY_W-1:0]       delay_reg;
    logic [avsfs_pkg::NUM_W-1:0]         num_reg;
    logic                                neg_reg;
    logic [avsfs_pkg::BPS_W-1:0]         bps_reg;
    logic                                use_corr_reg;
    logic signed [avsfs_pkg::DIFF_W-1:0] diff_reg;
    logic [avsfs_pkg::ADJ_W-1:0]         adj_reg;
    logic [avsfs_pkg::ROUND_W-1:0]       x_reg;
    logic                                sat_reg;
    logic [avsfs_pkg::PROD_W-1:0]        prod_reg;

    // Result register.
    logic [avsfs_pkg::MS_W-1:0]          interval_reg;
    logic                                show_reg;
    logic [avsfs_pkg::SLOT_W-1:0]        slot_reg;

    // Combinational values.
    logic signed [avsfs_pkg::STEP_W-1:0] step;
    logic                                step_ok;
    logic [avsfs_pkg::DELAY_W-1:0]       delay_next;
    logic signed [avsfs_pkg::BUF_W:0]    pending;
    logic [avsfs_pkg::BUF_W:0]           pending_mag;
    logic [avsfs_pkg::NUM_W-1:0]         num_next;
    logic [avsfs_pkg::BPS_W-2:0]         bps_half;
    logic [avsfs_pkg::BPS_W-1:0]         bps_next;
    logic                                div_done;
    logic [avsfs_pkg::NUM_W-1:0]         quotient;
    logic [avsfs_pkg::DIFF_W-1:0]        corr;
    logic signed [avsfs_pkg::DIFF_W-1:0] diff_next;
    logic [avsfs_pkg::DIFF_W-1:0]        abs_diff;
    logic [avsfs_pkg::DELAY_W-1:0]       thr;
    logic signed [avsfs_pkg::DIFF_W-1:0] thr_s;
    logic                                in_window;
    logic                                video_late;
    logic                                video_early;
    logic [avsfs_pkg::ADJ_W-1:0]         adj_next;
    logic signed [avsfs_pkg::WAIT_W-1:0] wait_raw;
    logic [avsfs_pkg::ROUND_W-1:0]       wait_clamped;
    logic [avsfs_pkg::SLOT_W:0]          slot_inc;
    logic [avsfs_pkg::SLOT_W-1:0]        read_slot_next;
    logic [avsfs_pkg::MS_W-1:0]          frame_ms;

    avsfs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (num_reg),
        .divisor  (bps_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign status.div_done = div_done;

    // Frame delay from the pts step, with fallback to the last delay.
    assign step       = avsfs_pkg::STEP_W'(pts_reg) - avsfs_pkg::STEP_W'(last_pts_reg);
    assign step_ok    = (step > 0) && (step < avsfs_pkg::MAX_STEP_US);
    assign delay_next = step_ok ? step[avsfs_pkg::DELAY_W-1:0] : last_delay_reg;

    // Pending audio bytes scaled to microseconds; the sign is handled apart.
    assign pending     = $signed({1'b0, buf_size_reg}) - $signed({1'b0, buf_index_reg});
    assign pending_mag = pending[avsfs_pkg::BUF_W] ? (~pending + 1'b1) : pending;
    assign num_next    = avsfs_pkg::NUM_W'(pending_mag[avsfs_pkg::BUF_W-1:0])
                       * avsfs_pkg::NUM_W'(avsfs_pkg::ONE_SECOND_US);
    assign bps_half    = (avsfs_pkg::BPS_W-1)'(sample_rate_reg)
                       * (avsfs_pkg::BPS_W-1)'(channel_count_reg);
    assign bps_next    = {bps_half, 1'b0};

    // Clock difference; a positive pending count pulls the audio clock back.
    assign corr      = use_corr_reg ? avsfs_pkg::DIFF_W'(quotient) : '0;
    assign diff_next = avsfs_pkg::DIFF_W'(pts_reg) - avsfs_pkg::DIFF_W'(aclk_reg)
                     + (neg_reg ? (~corr + 1'b1) : corr);

    // Sync decision inside the no-sync window.
    assign abs_diff    = diff_reg[avsfs_pkg::DIFF_W-1] ? (~diff_reg + 1'b1) : diff_reg;
    assign thr         = (delay_reg > avsfs_pkg::DELAY_W'(sync_thr_reg))
                       ? delay_reg : avsfs_pkg::DELAY_W'(sync_thr_reg);
    assign thr_s       = $signed(avsfs_pkg::DIFF_W'(thr));
    assign in_window   = abs_diff < avsfs_pkg::DIFF_W'(nosync_thr_reg);
    assign video_late  = diff_reg <= -thr_s;
    assign video_early = diff_reg >= thr_s;

    always_comb
    begin
        adj_next = avsfs_pkg::ADJ_W'(delay_reg);
        if (in_window)
        begin
            if (video_late)
            begin
                adj_next = '0;
            end
            else if (video_early)
            begin
                adj_next = {delay_reg, 1'b0};
            end
        end
    end

    // Wait until the frame timer expires, at least the minimum wait.
    assign wait_raw     = avsfs_pkg::WAIT_W'(frame_timer_reg)
                        - $signed(avsfs_pkg::WAIT_W'(now_reg));
    assign wait_clamped = (wait_raw < avsfs_pkg::MIN_WAIT_US)
                        ? avsfs_pkg::ROUND_W'(avsfs_pkg::MIN_WAIT_US)
                        : wait_raw[avsfs_pkg::ROUND_W-1:0];

    // Divide by 1000 through a scaled reciprocal; exact below the saturation point.
    assign frame_ms = sat_reg ? avsfs_pkg::MAX_INTERVAL_MS
                              : prod_reg[avsfs_pkg::RECIP_SHIFT +: avsfs_pkg::MS_W];

    assign slot_inc       = {1'b0, read_slot_reg} + (avsfs_pkg::SLOT_W+1)'(1);
    assign read_slot_next = (slot_inc >= (avsfs_pkg::SLOT_W+1)'(avsfs_pkg::QUEUE_DEPTH))
                          ? '0 : slot_inc[avsfs_pkg::SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg   <= avsfs_pkg::SR_RESET;
            channel_count_reg <= avsfs_pkg::CH_RESET;
            sync_thr_reg      <= avsfs_pkg::SYNC_RESET;
            nosync_thr_reg    <= avsfs_pkg::NOSYNC_RESET;
            last_pts_reg      <= '0;
            last_delay_reg    <= avsfs_pkg::DELAY_RESET;
            frame_timer_reg   <= '0;
            read_slot_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (avsfs_pkg::cfg_reg_t'(cfg_index))
                    avsfs_pkg::REG_SAMPLE_RATE:
                        sample_rate_reg <= cfg_data[avsfs_pkg::SR_W-1:0];
                    avsfs_pkg::REG_CHANNEL_COUNT:
                        channel_count_reg <= cfg_data[avsfs_pkg::CH_W-1:0];
                    avsfs_pkg::REG_SYNC_THRESHOLD:
                        sync_thr_reg <= cfg_data[avsfs_pkg::SYNC_W-1:0];
                    avsfs_pkg::REG_NOSYNC_THRESHOLD:
                        nosync_thr_reg <= cfg_data[avsfs_pkg::NOSYNC_W-1:0];
                    default:
                        ;
                endcase
            end
            if (cmd.restart)
            begin
                frame_timer_reg <= avsfs_pkg::TIME_W'(in_data[avsfs_pkg::NOW_LSB +: avsfs_pkg::NOW_W]);
            end
            else if (cmd.timer_adv)
            begin
                frame_timer_reg <= frame_timer_reg + avsfs_pkg::TIME_W'(adj_reg);
            end
            if (cmd.prep)
            begin
                last_delay_reg <= delay_next;
                last_pts_reg   <= pts_reg;
            end
            if (cmd.load_out && (cmd.kind == avsfs_pkg::KIND_FRAME))
            begin
                read_slot_reg <= read_slot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg       <= in_data[avsfs_pkg::NOW_LSB +: avsfs_pkg::NOW_W];
            pts_reg       <= in_data[avsfs_pkg::PTS_LSB +: avsfs_pkg::TIME_W];
            audio_reg     <= in_data[avsfs_pkg::AUDIO_BIT];
            aclk_reg      <= in_data[avsfs_pkg::ACLK_LSB +: avsfs_pkg::TIME_W];
            buf_size_reg  <= in_data[avsfs_pkg::BUF_SIZE_LSB +: avsfs_pkg::BUF_W];
            buf_index_reg <= in_data[avsfs_pkg::BUF_INDEX_LSB +: avsfs_pkg::BUF_W];
        end
        if (cmd.prep)
        begin
            delay_reg    <= delay_next;
            num_reg      <= num_next;
            neg_reg      <= pending[avsfs_pkg::BUF_W];
            bps_reg      <= bps_next;
            use_corr_reg <= audio_reg && (bps_next != '0);
        end
        if (cmd.ref_calc)
        begin
            diff_reg <= diff_next;
        end
        if (cmd.decide)
        begin
            adj_reg <= adj_next;
        end
        if (cmd.wait_calc)
        begin
            x_reg   <= wait_clamped + avsfs_pkg::HALF_MS_US;
            sat_reg <= (wait_raw >= avsfs_pkg::SAT_WAIT_US);
        end
        if (cmd.mul)
        begin
            prod_reg <= avsfs_pkg::PROD_W'(x_reg) * avsfs_pkg::PROD_W'(avsfs_pkg::RECIP_MS);
        end
        if (cmd.load_out)
        begin
            case (cmd.kind)
                avsfs_pkg::KIND_NO_VIDEO:
                begin
                    interval_reg <= avsfs_pkg::NO_VIDEO_MS;
                    show_reg     <= 1'b0;
                    slot_reg     <= '0;
                end
                avsfs_pkg::KIND_EMPTY:
                begin
                    interval_reg <= avsfs_pkg::EMPTY_QUEUE_MS;
                    show_reg     <= 1'b0;
                    slot_reg     <= '0;
                end
                avsfs_pkg::KIND_FRAME:
                begin
                    interval_reg <= frame_ms;
                    show_reg     <= 1'b1;
                    slot_reg     <= read_slot_reg;
                end
                default:
                begin
                    interval_reg <= '0;
                    show_reg     <= 1'b0;
                    slot_reg     <= '0;
                end
            endcase
        end
    end

    assign out_data = {{avsfs_pkg::OUT_PAD_W{1'b0}}, slot_reg, show_reg, interval_reg};

endmodule

/* design/avsfs_ctrl.sv */
// Controller: sequences one item through the datapath and owns the handshakes.
`include "assert_macros.svh"

module avsfs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_action,
    input  logic                 in_video,
    input  logic                 in_picture,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  avsfs_pkg::status_t   status,
    output avsfs_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_REF,
        ST_DECIDE,
        ST_TIMER,
        ST_WAIT,
        ST_MUL,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    avsfs_pkg::out_kind_t   kind_reg;
    avsfs_pkg::out_kind_t   kind_next;
    logic                   in_accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.kind       = kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_action == avsfs_pkg::ACT_RESTART)
                    begin
                        cmd.restart = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        if (!in_video)
                        begin
                            kind_next  = avsfs_pkg::KIND_NO_VIDEO;
                            state_next = ST_EMIT;
                        end
                        else if (!in_picture)
                        begin
                            kind_next  = avsfs_pkg::KIND_EMPTY;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            kind_next  = avsfs_pkg::KIND_FRAME;
                            state_next = ST_PREP;
                        end
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_REF;
                end
            end
            ST_REF:
            begin
                cmd.ref_calc = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_TIMER;
            end
            ST_TIMER:
            begin
                cmd.timer_adv = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                cmd.wait_calc = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            kind_reg      <= avsfs_pkg::KIND_NO_VIDEO;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
        end
    end

    `ASSERT_NXT(a_restart_no_result, in_accept && (in_action == avsfs_pkg::ACT_RESTART), (state_reg == ST_IDLE) && !$rose(out_valid_reg))
    `ASSERT_NXT(a_no_video_short_path, in_accept && (in_action == avsfs_pkg::ACT_TICK) && !in_video, state_reg == ST_EMIT)
    `ASSERT_IMP(a_long_path_is_frame, state_reg == ST_PREP, kind_reg == avsfs_pkg::KIND_FRAME)

endmodule

/* design/av_sync_frame_scheduler_top.sv */
// Top level of the audio/video sync frame scheduler.
// A tick that shows a picture passes prep, the bit-serial audio-correction divide, the clock
// difference, sync decision, timer advance, wait and multiply before tvalid rises; a tick
// without video or picture goes straight to the output. One item at a time: the next transfer
// is taken after a tick's result is loaded, past any output stall; a restart gives no result.
// Reset (rst_n, asynchronous, active low): register defaults, 40 ms last delay, other state 0.
module av_sync_frame_scheduler_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream. tdata from bit 0 up: now_us[46:0], video_present, picture_ready,
    // frame_pts_us[47:0], audio_present, audio_clock_us[47:0], buf_bytes[19:0],
    // buf_played[19:0], zero fill.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [avsfs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser from bit 0 up: action (0 refresh tick, 1 restart the frame timer).
    input  logic [avsfs_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // Output stream. tdata from bit 0 up: interval_ms[15:0], show_frame, frame_slot[3:0],
    // zero fill.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [avsfs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // Configuration writes: sample rate, channel count, sync and no-sync thresholds.
    input  logic                                cfg_we,
    input  logic [avsfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [avsfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    avsfs_pkg::cmd_t     cmd;
    avsfs_pkg::status_t  status;

    // The controller decides the path of an item from its action and its two
    // stream flags at the moment of the transfer; the datapath captures the rest.
    // A finished result waits in the output register while the next item is taken.
    avsfs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_action  (s_axis_tuser[0]),
        .in_video   (s_axis_tdata[avsfs_pkg::VIDEO_BIT]),
        .in_picture (s_axis_tdata[avsfs_pkg::PICTURE_BIT]),
        .in_ready   (s_axis_tready),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath holds the configuration, the scheduler state, the divider and
    // the output payload.
    avsfs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata)
    );

endmodule
